[sv/ids2a_pkg.sv]
package ids2a_pkg;

  // frame size limits
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // field and register widths
  localparam int PIX_W = 8;
  localparam int SUM_W = PIX_W + 1;
  localparam int DIM_W = 13;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  // line buffer holds one pair sum per output column
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int LINE_AW    = $clog2(LINE_DEPTH);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  // source of an output pixel
  typedef enum logic [1:0] {
    SEL_AVG  = 2'd0,
    SEL_LINE = 2'd1,
    SEL_PIX  = 2'd2
  } sel_t;

  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
    logic [SUM_W-1:0]   data;
  } line_wr_t;

  typedef struct packed {
    logic               en;
    logic [LINE_AW-1:0] addr;
  } line_rd_t;

endpackage

[sv/ids2a_line_buf.sv]
module ids2a_line_buf (
  input  logic                          clk,
  input  ids2a_pkg::line_wr_t           wr,
  input  ids2a_pkg::line_rd_t           rd,
  output logic [ids2a_pkg::SUM_W-1:0]   rd_data
);

  logic [ids2a_pkg::SUM_W-1:0] mem [ids2a_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // registered read, old data on a same-cycle collision
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data <= mem[rd.addr];
    end
  end

endmodule

[sv/image_downsample_2x2_average.sv]
// 2x2 box-filter downsampler. Grayscale pixels enter in raster order, one per
// clock when both sides keep up, and leave as a half-size image whose samples
// are the floor of the mean of each 2x2 block. An odd width makes the last
// output column a copy of the upper pixel of its row pair, an odd height makes
// the last output row every even-column pixel of the last input row, and the
// corner then takes the last pixel. out_row_end marks the last pixel of each
// output row and out_frame_end the last pixel of the frame. Each transaction
// passes two stages: the line buffer read (or pair-sum write) at acceptance,
// then the average, then the output register. Throughput is one pixel per
// cycle while out_ready keeps up, set by one read and one write of the line
// buffer memory per cycle. image_width and image_height (index 0 and 1) take
// effect at once; zero counts as one and values above 4096 count as 4096.
// There is no memory clearing pass.
module image_downsample_2x2_average (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ids2a_pkg::PIX_W-1:0]       in_pixel_in,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ids2a_pkg::PIX_W-1:0]       out_pixel_out,
  output logic                              out_row_end,
  output logic                              out_frame_end,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ids2a_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ids2a_pkg::DIM_W-1:0]       cfg_data
);

  localparam int PW = ids2a_pkg::PIX_W;
  localparam int SW = ids2a_pkg::SUM_W;
  localparam int DW = ids2a_pkg::DIM_W;
  localparam int CW = ids2a_pkg::COL_W;
  localparam int RW = ids2a_pkg::ROW_W;

  // configuration registers
  logic [DW-1:0] width_r,  width_nxt;
  logic [DW-1:0] height_r, height_nxt;

  // position and left neighbor
  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [PW-1:0] left_r, left_nxt;

  // stage 1: waits for the line buffer read data
  logic                  s1_valid_r, s1_valid_nxt;
  ids2a_pkg::sel_t       s1_sel_r;
  logic [PW-1:0]         s1_left_r;
  logic [PW-1:0]         s1_px_r;
  logic                  s1_rend_r;
  logic                  s1_fend_r;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [PW-1:0]         out_pix_r;
  logic                  out_rend_r;
  logic                  out_fend_r;

  logic                  in_acc;
  logic                  s1_adv;
  logic [DW-1:0]         w_cl, h_cl;
  logic [CW-1:0]         w_m1;
  logic [RW-1:0]         h_m1;
  logic                  last_col, last_row, col_odd, near_last;
  logic                  emit;
  ids2a_pkg::sel_t       sel;
  logic                  rend;
  ids2a_pkg::line_wr_t   lwr;
  ids2a_pkg::line_rd_t   lrd;
  logic [SW-1:0]         line_q;
  logic [SW:0]           blk_sum;
  logic [PW-1:0]         s1_val;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ids2a_pkg::REG_IMAGE_WIDTH:  width_nxt  = cfg_data;
        ids2a_pkg::REG_IMAGE_HEIGHT: height_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // clamp to 1..max
  always_comb begin
    if (width_r == '0) begin
      w_cl = DW'(1);
    end else if (width_r > DW'(ids2a_pkg::MAX_WIDTH)) begin
      w_cl = DW'(ids2a_pkg::MAX_WIDTH);
    end else begin
      w_cl = width_r;
    end
    if (height_r == '0) begin
      h_cl = DW'(1);
    end else if (height_r > DW'(ids2a_pkg::MAX_HEIGHT)) begin
      h_cl = DW'(ids2a_pkg::MAX_HEIGHT);
    end else begin
      h_cl = height_r;
    end
  end

  assign w_m1 = CW'(w_cl - DW'(1));
  assign h_m1 = RW'(h_cl - DW'(1));

  // ---------------------------------------------------------------------------
  // handshake: stage 1 drains into the output register when that is free
  // ---------------------------------------------------------------------------
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // stage 0: classify the pixel, update counters, access the line buffer
  // ---------------------------------------------------------------------------
  assign last_col  = col_r >= w_m1;
  assign last_row  = row_r >= h_m1;
  assign col_odd   = col_r[0];
  assign near_last = ({1'b0, col_r} + (CW+1)'(1)) >= {1'b0, w_m1};

  always_comb begin
    emit     = 1'b0;
    sel      = ids2a_pkg::SEL_AVG;
    rend     = 1'b0;
    left_nxt = left_r;
    lwr.en   = 1'b0;
    lwr.addr = col_r[CW-1:1];
    lwr.data = SW'(left_r) + SW'(in_pixel_in);
    if (h_cl[0] && last_row) begin
      // single last row of an odd-height frame
      if (!col_odd) begin
        emit = 1'b1;
        sel  = ids2a_pkg::SEL_PIX;
        rend = last_col || near_last;
      end
    end else if (!row_r[0]) begin
      // upper row of a pair stores pair sums
      if (col_odd) begin
        lwr.en = 1'b1;
      end else if (last_col) begin
        lwr.en   = 1'b1;
        lwr.data = SW'(in_pixel_in);
      end else begin
        left_nxt = in_pixel_in;
      end
    end else begin
      // lower row of a pair completes the blocks
      if (col_odd) begin
        emit = 1'b1;
        sel  = ids2a_pkg::SEL_AVG;
        rend = last_col;
      end else if (last_col) begin
        emit = 1'b1;
        sel  = ids2a_pkg::SEL_LINE;
        rend = 1'b1;
      end else begin
        left_nxt = in_pixel_in;
      end
    end
    lwr.en = lwr.en && in_acc;
    if (!in_acc) begin
      left_nxt = left_r;
    end
  end

  // every accepted pixel reads its column pair; a write from an earlier
  // transaction lands on an edge before any later read, so no forwarding is needed
  assign lrd.en   = in_acc;
  assign lrd.addr = col_r[CW-1:1];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  ids2a_line_buf u_line_buf (
    .clk     (clk),
    .wr      (lwr),
    .rd      (lrd),
    .rd_data (line_q)
  );

  // ---------------------------------------------------------------------------
  // stage 1: block average or edge copy
  // ---------------------------------------------------------------------------
  assign blk_sum = (SW+1)'(line_q) + (SW+1)'(s1_left_r) + (SW+1)'(s1_px_r);

  always_comb begin
    case (s1_sel_r)
      ids2a_pkg::SEL_AVG:  s1_val = blk_sum[PW+1:2];
      ids2a_pkg::SEL_LINE: s1_val = line_q[PW-1:0];
      ids2a_pkg::SEL_PIX:  s1_val = s1_px_r;
      default:             s1_val = s1_px_r;
    endcase
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = emit;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DW'(640);
      height_r    <= DW'(480);
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      left_r      <= left_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sel_r  <= sel;
      s1_left_r <= left_r;
      s1_px_r   <= in_pixel_in;
      s1_rend_r <= rend;
      s1_fend_r <= rend && last_row;
    end
    if (s1_adv) begin
      out_pix_r  <= s1_val;
      out_rend_r <= s1_rend_r;
      out_fend_r <= s1_fend_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_row_end   = out_rend_r;
  assign out_frame_end = out_fend_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |-> !in_acc)
    else $error("stage 1 overwritten while stalled");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fend_r) |-> out_rend_r)
    else $error("frame end without row end");

  a_col_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && last_col) |=> (col_r == '0))
    else $error("column counter did not wrap");

  a_write_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !(lwr.en && emit))
    else $error("line write and result from one transaction");

endmodule

[test/tb_image_downsample_2x2_average.sv]
`timescale 1ns / 100ps

module tb_image_downsample_2x2_average;
  import ids2a_pkg::*;

  // one downsampled pixel as it leaves the block
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             row_end;
    logic             frame_end;
  } ds_pixel_t;

  // bit-true picture of the downsampler: register copies, line of pair sums,
  // raster position, and the output pixels still owed by the block
  class box_avg_model;
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [SUM_W-1:0] pair_sums [0:LINE_DEPTH];
    logic [PIX_W-1:0] left_pix;
    int               col_count;
    int               row_count;
    ds_pixel_t        owed_q[$];
    int               n_errors;

    function new();
      width_reg  = 13'd640;
      height_reg = 13'd480;
      foreach (pair_sums[i]) pair_sums[i] = '0;
      left_pix   = '0;
      col_count  = 0;
      row_count  = 0;
      n_errors   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      if (idx == REG_IMAGE_WIDTH) width_reg = val;
      else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
    endfunction

    function int eff_dim(logic [DIM_W-1:0] v, int lim);
      if (v == 0) return 1;
      if (int'(v) > lim) return lim;
      return int'(v);
    endfunction

    function void take_pixel(logic [PIX_W-1:0] px);
      int               w;
      int               h;
      int               idx;
      bit               last_col;
      bit               last_row;
      bit               col_odd;
      bit               emit;
      bit               rend;
      logic [SUM_W+1:0] sum;
      ds_pixel_t        r;
      w        = eff_dim(width_reg, MAX_WIDTH);
      h        = eff_dim(height_reg, MAX_HEIGHT);
      last_col = col_count >= w - 1;
      last_row = row_count >= h - 1;
      col_odd  = (col_count % 2) == 1;
      idx      = (col_count >> 1) % (LINE_DEPTH + 1);
      emit     = 1'b0;
      rend     = 1'b0;
      r        = '0;
      if ((h % 2) == 1 && last_row) begin
        if (!col_odd) begin
          emit    = 1'b1;
          r.pixel = px;
          rend    = last_col || (col_count + 1 >= w - 1);
        end
      end else if ((row_count % 2) == 0) begin
        if (col_odd) pair_sums[idx] = left_pix + px;
        else if (last_col) pair_sums[idx] = {1'b0, px};
        else left_pix = px;
      end else begin
        if (col_odd) begin
          sum     = pair_sums[idx] + left_pix + px;
          emit    = 1'b1;
          r.pixel = sum[PIX_W+1:2];
          rend    = last_col;
        end else if (last_col) begin
          emit    = 1'b1;
          r.pixel = pair_sums[idx][PIX_W-1:0];
          rend    = 1'b1;
        end else begin
          left_pix = px;
        end
      end
      if (last_col) begin
        col_count = 0;
        row_count = last_row ? 0 : ((row_count + 1) & 'hFFF);
      end else begin
        col_count = (col_count + 1) & 'hFFF;
      end
      if (emit) begin
        r.row_end   = rend;
        r.frame_end = rend && last_row;
        owed_q.push_back(r);
      end
    endfunction

    task report(string msg);
      $display("%0t mismatch: %s", $time, msg);
      n_errors++;
    endtask

    task check_pixel(logic [PIX_W-1:0] pix, logic rend, logic fend);
      ds_pixel_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("output pixel %0d with nothing owed", pix));
        return;
      end
      want = owed_q.pop_front();
      if (pix !== want.pixel)
        report($sformatf("pixel_out %0d, want %0d", pix, want.pixel));
      if (rend !== want.row_end)
        report($sformatf("row_end %b, want %b", rend, want.row_end));
      if (fend !== want.frame_end)
        report($sformatf("frame_end %b, want %b", fend, want.frame_end));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [PIX_W-1:0]   in_pixel_in;
  logic               out_valid;
  logic               out_ready;
  logic [PIX_W-1:0]   out_pixel_out;
  logic               out_row_end;
  logic               out_frame_end;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]   cfg_data;

  box_avg_model model;
  bit           calm;        // both sides run without gaps
  int           long_hold;   // one-shot long stall for the output side
  int           n_sent;

  image_downsample_2x2_average uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_row_end   (out_row_end),
    .out_frame_end (out_frame_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle cycles before the next transaction, none in calm stretches
  function automatic int draw_gap();
    if (calm) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // pixel values lean toward black and white
  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // offer one pixel; returns at the edge that accepts it
  task automatic send(logic [PIX_W-1:0] px);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    do @(posedge clk); while (!(in_valid && in_ready));
    model.take_pixel(px);
    n_sent++;
  endtask

  // register write only once the block has drained and settled
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    in_valid <= 1'b0;
    while (model.owed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    model.set_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // keep feeding until the raster position wraps to the frame origin
  task automatic finish_frame();
    do send(rand_pixel()); while (model.col_count != 0 || model.row_count != 0);
  endtask

  task automatic run_frame(int w, int h);
    write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
    write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
    finish_frame();
  endtask

  // output side holds off for a long stretch while pixels keep coming
  task automatic pressure_frame();
    calm      = 1'b1;
    long_hold = 300;
    run_frame(16, 8);
    calm      = 1'b0;
  endtask

  // result side: random ready gaps, check each accepted transaction
  initial begin : result_sink
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (long_hold > 0) begin
        gap       = long_hold;
        long_hold = 0;
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      model.check_pixel(out_pixel_out, out_row_end, out_frame_end);
    end
  end

  // main stimulus
  initial begin : stimulus
    int rand_target;
    int w;
    int h;
    int k;
    int c;
    model       = new();
    calm        = 1'b0;
    long_hold   = 0;
    n_sent      = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_pixel_in = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_IMAGE_WIDTH;
    cfg_data    = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset sizes: part of an upper row, then narrow the width under it so
    // the current column is already past the new last one
    send(8'd255);
    send(8'd255);
    send(8'd0);
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    send(8'd128);
    // lower row with all-white block: largest pair sum and largest average
    write_reg(REG_IMAGE_HEIGHT, 13'd2);
    send(8'd255);
    send(8'd255);

    // zero sizes count as one: single-pixel frames
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    send(8'hA5);
    send(8'h5A);

    // odd width and odd height: copied edge column, copied last row, corner
    run_frame(3, 3);

    // sizes beyond the maximum clamp; then shrink mid-row and cut the
    // height so the next upper row becomes the last row of an odd frame
    write_reg(REG_IMAGE_WIDTH, 13'd8191);
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    send(8'd0);
    send(8'd255);
    write_reg(REG_IMAGE_WIDTH, 13'd2);
    send(8'd1);
    send(8'd7);
    send(8'd9);
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    send(8'd200);
    send(8'd100);

    // random frames with mid-frame size changes mixed in
    rand_target = n_sent + 820;
    pressure_frame();
    while (n_sent < rand_target) begin
      calm = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0:       w = 0;
        1:       w = 1;
        2:       w = $urandom_range(11, 40);
        default: w = $urandom_range(2, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       h = 0;
        1:       h = 1;
        default: h = $urandom_range(2, 8);
      endcase
      case ($urandom_range(0, 9))
        0: begin
          // wide or oversized row cut short while still on an upper row
          case ($urandom_range(0, 2))
            0:       write_reg(REG_IMAGE_WIDTH, 13'd4096);
            1:       write_reg(REG_IMAGE_WIDTH, 13'd8191);
            default: write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(16, 200)));
          endcase
          write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(1, 6)));
          k = $urandom_range(1, 14);
          repeat (k) send(rand_pixel());
          write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(0, k + 3)));
          finish_frame();
        end
        1: begin
          // height changed at the start of the second row pair
          write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(1, 12)));
          write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(3, 8)));
          while (!(model.row_count == 2 && model.col_count == 0)) send(rand_pixel());
          write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(0, 4)));
          finish_frame();
        end
        2: begin
          // lower row ended early by a narrower width
          w = $urandom_range(3, 20);
          write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
          write_reg(REG_IMAGE_HEIGHT, DIM_W'($urandom_range(2, 6)));
          c = $urandom_range(0, w - 1);
          while (!(model.row_count == 1 && model.col_count == c)) send(rand_pixel());
          write_reg(REG_IMAGE_WIDTH, DIM_W'($urandom_range(0, c + 1)));
          finish_frame();
        end
        default: run_frame(w, h);
      endcase
    end
    pressure_frame();

    // drain and let the pipeline settle
    in_valid <= 1'b0;
    while (model.owed_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (model.n_errors == 0) begin
      $display("tb_image_downsample_2x2_average passed");
    end else begin
      $display("tb_image_downsample_2x2_average failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin : watchdog
    #4_000_000;
    $display("tb_image_downsample_2x2_average failed");
    $finish;
  end

endmodule
